/* rtl/odtl_pkg.sv */
// Shared types, constants and the DAC channel map of the offset DAC table loader.
package odtl_pkg;

  localparam int unsigned ChannelsDefault = 16;
  localparam int unsigned NumDacs         = 8;
  localparam int unsigned DacW            = 3;
  localparam int unsigned ChanW           = 5;
  localparam int unsigned OffsetW         = 10;
  localparam int unsigned WordW           = 32;

  localparam logic [OffsetW-1:0] OffsetMax  = 10'd1023;
  localparam logic [WordW-1:0]   ChipSelect = 32'h8000_0000;

  typedef enum logic [1:0] {
    CMD_SET    = 2'd0,
    CMD_READ   = 2'd1,
    CMD_COMMIT = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    RES_SINGLE = 2'd0,
    RES_WORD   = 2'd1,
    RES_CSEL   = 2'd2
  } res_kind_e;

  typedef struct packed {
    logic             accept;
    logic             use_chan;
    logic             ren;
    logic [DacW-1:0]  dac;
    logic             load;
    res_kind_e        kind;
    logic             last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic slot_free;
  } dp_status_t;

  // First channel of the pair that feeds each DAC, numbered from 1.
  function automatic logic [ChanW-1:0] map_first(input logic [DacW-1:0] dac);
    logic [ChanW-1:0] ch;
    case (dac)
      3'd0:    ch = 5'd3;
      3'd1:    ch = 5'd7;
      3'd2:    ch = 5'd4;
      3'd3:    ch = 5'd8;
      3'd4:    ch = 5'd16;
      3'd5:    ch = 5'd12;
      3'd6:    ch = 5'd15;
      default: ch = 5'd11;
    endcase
    return ch;
  endfunction

  // Second channel of the pair that feeds each DAC, numbered from 1.
  function automatic logic [ChanW-1:0] map_second(input logic [DacW-1:0] dac);
    logic [ChanW-1:0] ch;
    case (dac)
      3'd0:    ch = 5'd1;
      3'd1:    ch = 5'd5;
      3'd2:    ch = 5'd2;
      3'd3:    ch = 5'd6;
      3'd4:    ch = 5'd14;
      3'd5:    ch = 5'd10;
      3'd6:    ch = 5'd13;
      default: ch = 5'd9;
    endcase
    return ch;
  endfunction

endpackage

/* rtl/offset_dac_table_loader_core.sv */
// Top level of the offset DAC table loader: controller and datapath.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid_i/in_stall_o  cmd, channel, value
//   out      output     out_valid_o/out_stall_i status, read_value, is_bus_write,
//                                              bus_word, last
//
// A set or read item is accepted, then the output register is loaded from the
// registered table read port once it is free. A commit item gives its 16 beats,
// one per cycle while the output is not stalled, paced by the output register;
// the next item is taken after the last.
// Reset clears the controller, the output valid and the table valid bits, so
// every channel reads as zero until it is set. Stalls on the output hold the
// pending beat and pause the controller; input stall is high while an item runs.
module offset_dac_table_loader_core #(
  parameter int unsigned CHANNELS = odtl_pkg::ChannelsDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           in_cmd_i,
  input  logic [odtl_pkg::ChanW-1:0]           in_channel_i,
  input  logic signed [odtl_pkg::WordW-1:0]    in_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 out_status_o,
  output logic [odtl_pkg::OffsetW-1:0]         out_read_value_o,
  output logic                                 out_is_bus_write_o,
  output logic [odtl_pkg::WordW-1:0]           out_bus_word_o,
  output logic                                 out_last_o
);

  odtl_pkg::ctrl_cmd_t  ctrl_cmd;
  odtl_pkg::dp_status_t dp_sts;

  odtl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_cmd_i),
    .in_stall_o (in_stall_o),
    .sts_i      (dp_sts),
    .cmd_o      (ctrl_cmd)
  );

  odtl_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_cmd_i           (in_cmd_i),
    .in_channel_i       (in_channel_i),
    .in_value_i         (in_value_i),
    .cmd_i              (ctrl_cmd),
    .sts_o              (dp_sts),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_status_o       (out_status_o),
    .out_read_value_o   (out_read_value_o),
    .out_is_bus_write_o (out_is_bus_write_o),
    .out_bus_word_o     (out_bus_word_o),
    .out_last_o         (out_last_o)
  );

endmodule

/* rtl/odtl_ctrl.sv */
// Controller state machine that sequences set, read and commit items.
module odtl_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [1:0]             in_cmd_i,
  output logic                   in_stall_o,
  input  odtl_pkg::dp_status_t   sts_i,
  output odtl_pkg::ctrl_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RESULT,
    ST_CWORD,
    ST_CSEL
  } state_e;

  state_e                      state_q, state_d;
  logic [odtl_pkg::DacW-1:0]   dac_q, dac_d;
  logic                        accept;
  logic                        last_dac;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign last_dac   = (dac_q == odtl_pkg::DacW'(odtl_pkg::NumDacs - 1));

  always_comb begin
    state_d       = state_q;
    dac_d         = dac_q;
    cmd_o         = '0;
    cmd_o.accept  = accept;
    cmd_o.kind    = odtl_pkg::RES_SINGLE;
    case (state_q)
      ST_IDLE: begin
        cmd_o.ren      = 1'b1;
        cmd_o.use_chan = (in_cmd_i != odtl_pkg::CMD_COMMIT);
        if (accept) begin
          if (in_cmd_i == odtl_pkg::CMD_SET || in_cmd_i == odtl_pkg::CMD_READ) begin
            state_d = ST_RESULT;
          end else if (in_cmd_i == odtl_pkg::CMD_COMMIT) begin
            state_d = ST_CWORD;
          end
        end
      end
      ST_RESULT: begin
        if (sts_i.slot_free) begin
          cmd_o.load = 1'b1;
          cmd_o.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_CWORD: begin
        cmd_o.ren = 1'b1;
        if (sts_i.slot_free) begin
          cmd_o.load = 1'b1;
          cmd_o.kind = odtl_pkg::RES_WORD;
          state_d    = ST_CSEL;
        end
      end
      ST_CSEL: begin
        cmd_o.ren = 1'b1;
        if (sts_i.slot_free) begin
          cmd_o.load = 1'b1;
          cmd_o.kind = odtl_pkg::RES_CSEL;
          cmd_o.last = last_dac;
          dac_d      = dac_q + 1'b1;
          state_d    = last_dac ? ST_IDLE : ST_CWORD;
        end
      end
      default: begin
        state_d = ST_IDLE;
        dac_d   = '0;
      end
    endcase
    cmd_o.dac = dac_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      dac_q   <= '0;
    end else begin
      state_q <= state_d;
      dac_q   <= dac_d;
    end
  end

  a_load_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> sts_i.slot_free)
    else $error("Result loaded while the output register is occupied.");

  a_idle_dac_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (dac_q == '0))
    else $error("DAC counter not back at zero when idle.");

  a_last_ends_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load && cmd_o.kind == odtl_pkg::RES_CSEL && cmd_o.last) |=>
      (state_q == ST_IDLE))
    else $error("Commit did not end after the final chip select.");

endmodule

/* rtl/odtl_datapath.sv */
// Datapath with the offset table memory, word packing and the output register.
module odtl_datapath #(
  parameter int unsigned CHANNELS = odtl_pkg::ChannelsDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [1:0]                           in_cmd_i,
  input  logic [odtl_pkg::ChanW-1:0]           in_channel_i,
  input  logic signed [odtl_pkg::WordW-1:0]    in_value_i,
  input  odtl_pkg::ctrl_cmd_t                  cmd_i,
  output odtl_pkg::dp_status_t                 sts_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 out_status_o,
  output logic [odtl_pkg::OffsetW-1:0]         out_read_value_o,
  output logic                                 out_is_bus_write_o,
  output logic [odtl_pkg::WordW-1:0]           out_bus_word_o,
  output logic                                 out_last_o
);

  localparam int unsigned IdxW = $clog2(CHANNELS);

  logic [odtl_pkg::OffsetW-1:0] mem [CHANNELS];
  logic [CHANNELS-1:0]          valid_q;

  logic [IdxW-1:0]              addr_a, addr_b, in_idx;
  logic                         ch_ok;
  logic [odtl_pkg::OffsetW-1:0] clamped;
  logic                         wen;

  logic [odtl_pkg::OffsetW-1:0] rd_a_q, rd_b_q;
  logic                         vld_a_q, vld_b_q;
  logic [odtl_pkg::OffsetW-1:0] x_val, y_val;

  logic                         is_read_q, ch_ok_q;
  logic [odtl_pkg::DacW:0]      dac_code;
  logic [odtl_pkg::DacW-1:0]    dac_q;

  logic                         out_valid_q;
  logic                         status_q, is_bus_write_q, last_q;
  logic [odtl_pkg::OffsetW-1:0] read_value_q;
  logic [odtl_pkg::WordW-1:0]   bus_word_q;

  assign in_idx = IdxW'(in_channel_i - 5'd1);
  assign ch_ok  = (in_channel_i != '0) &&
                  ({27'd0, in_channel_i} <= 32'(CHANNELS));

  always_comb begin
    if (in_value_i[odtl_pkg::WordW-1]) begin
      clamped = '0;
    end else if (|in_value_i[odtl_pkg::WordW-2:odtl_pkg::OffsetW]) begin
      clamped = odtl_pkg::OffsetMax;
    end else begin
      clamped = in_value_i[odtl_pkg::OffsetW-1:0];
    end
  end

  assign wen    = cmd_i.accept && (in_cmd_i == odtl_pkg::CMD_SET) && ch_ok;
  assign addr_a = cmd_i.use_chan ? in_idx
                                 : IdxW'(odtl_pkg::map_first(cmd_i.dac) - 5'd1);
  assign addr_b = IdxW'(odtl_pkg::map_second(cmd_i.dac) - 5'd1);

  always_ff @(posedge clk_i) begin
    if (wen) begin
      mem[in_idx] <= clamped;
    end
    if (cmd_i.ren) begin
      rd_a_q <= mem[addr_a];
      rd_b_q <= mem[addr_b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      if (wen) begin
        valid_q[in_idx] <= 1'b1;
      end
      if (cmd_i.ren) begin
        vld_a_q <= valid_q[addr_a];
        vld_b_q <= valid_q[addr_b];
      end
    end
  end

  assign x_val = vld_a_q ? rd_a_q : '0;
  assign y_val = vld_b_q ? rd_b_q : '0;

  always_ff @(posedge clk_i) begin
    dac_q <= cmd_i.dac;
    if (cmd_i.accept) begin
      is_read_q <= (in_cmd_i == odtl_pkg::CMD_READ);
      ch_ok_q   <= ch_ok;
    end
  end

  assign dac_code = {1'b0, dac_q} + 1'b1;

  assign sts_o.slot_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      last_q <= cmd_i.last;
      case (cmd_i.kind)
        odtl_pkg::RES_WORD: begin
          status_q       <= 1'b0;
          read_value_q   <= '0;
          is_bus_write_q <= 1'b1;
          bus_word_q     <= {2'b00, dac_code, x_val, 2'b00, dac_code, y_val};
        end
        odtl_pkg::RES_CSEL: begin
          status_q       <= 1'b0;
          read_value_q   <= '0;
          is_bus_write_q <= 1'b0;
          bus_word_q     <= odtl_pkg::ChipSelect;
        end
        default: begin
          status_q       <= !ch_ok_q;
          read_value_q   <= (is_read_q && ch_ok_q) ? x_val : '0;
          is_bus_write_q <= 1'b0;
          bus_word_q     <= '0;
        end
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_status_o       = status_q;
  assign out_read_value_o   = read_value_q;
  assign out_is_bus_write_o = is_bus_write_q;
  assign out_bus_word_o     = bus_word_q;
  assign out_last_o         = last_q;

  a_bus_write_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && is_bus_write_q) |-> (!last_q && !status_q))
    else $error("A bus write beat is marked last or carries a bad status.");

  a_csel_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !is_bus_write_q && (bus_word_q != '0)) |->
      (bus_word_q == odtl_pkg::ChipSelect))
    else $error("A non-write beat carries a word other than the chip select.");

  a_single_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !is_bus_write_q && (bus_word_q == '0)) |-> last_q)
    else $error("A set or read beat is not marked last.");

endmodule
